>>> sv/ccf_pkg.sv
package ccf_pkg;

  localparam int FILE_W  = 8;
  localparam int CMD_W   = 4;
  localparam int BLOCK_W = 32;
  localparam int STAT_W  = 3;
  localparam int OCC_W   = 5;

  // Input tdata: file_num, command_code, block_addr, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  // Output tdata: file, command, block, occupancy, peak, padded to whole bytes.
  localparam int OUT_DATA_W = 56;

  localparam logic [CMD_W-1:0] WRITE_CODE_RST = 4'd1;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_COALESCED = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_POPPED    = 3'd3,
    STAT_EMPTY     = 3'd4
  } ccf_status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } ccf_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } ccf_state_t;

  typedef struct packed {
    logic [FILE_W-1:0]  file;
    logic [CMD_W-1:0]   cmd;
    logic [BLOCK_W-1:0] block;
  } ccf_entry_t;

  typedef struct packed {
    logic shift;  // pop: take the upper neighbor's entry
    logic load;   // insert lands in this cell
    logic live;   // cell holds a queued command
  } ccf_cell_ctrl_t;

endpackage

>>> sv/ccf_cell.sv
module ccf_cell (
  input  logic                          clk,
  input  ccf_pkg::ccf_cell_ctrl_t       ctrl,
  input  ccf_pkg::ccf_entry_t           entry_up,
  input  ccf_pkg::ccf_entry_t           entry_new,
  input  logic [ccf_pkg::CMD_W-1:0]     write_code,
  input  logic [ccf_pkg::BLOCK_W-1:0]   cmp_addr,
  output ccf_pkg::ccf_entry_t           entry_q,
  output logic                          hit_q
);
  import ccf_pkg::*;

  ccf_entry_t entry_r;
  logic       hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry_r <= entry_new;
    end else if (ctrl.shift) begin
      entry_r <= entry_up;
    end
  end

  // A queued write to the same block, registered for the execute cycle.
  always_ff @(posedge clk) begin
    hit_r <= ctrl.live && (entry_r.cmd == write_code) && (entry_r.block == cmp_addr);
  end

  assign entry_q = entry_r;
  assign hit_q   = hit_r;

endmodule

>>> sv/coalescing_command_fifo.sv
// Channel  Dir  Handshake           Payload
// in       in   in_tvalid/tready    tuser: req_type; tdata: file, command, block address
// out      out  out_tvalid/tready   tuser: status; tdata: file, command, block, occ, peak
// cfg      in   cfg_wr_en           cfg_wr_data: write_code
//
// Each item passes in turn through accept, compare in every cell, and execute; a new item is accepted only in idle.
// The compare cycle registers one match flag per cell; execute ORs them.
// Reset clears the fill count, peak mark, control and write_code (to 1).
// A result waits in the output register; execute stalls only while that register
// holds an item that out_tready does not take.
module coalescing_command_fifo #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] file_num, [11:8] command_code, [43:12] block_addr
  input  logic [ccf_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_file_num, [11:8] out_command, [43:12] out_block_addr,
  // [48:44] occupancy, [53:49] peak_occupancy
  output logic [ccf_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [2:0] status
  output logic [ccf_pkg::STAT_W-1:0]       out_tuser,
  input  logic                             cfg_wr_en,
  input  logic [ccf_pkg::CMD_W-1:0]        cfg_wr_data
);
  import ccf_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ccf_state_t               state_r, state_nxt;
  logic [CMD_W-1:0]         write_code_r;
  logic                     req_r;
  ccf_entry_t               item_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         peak_r, peak_nxt;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [STAT_W-1:0]        out_user_r;

  logic                     exec_go;
  logic                     any_hit;
  logic                     is_write;
  logic                     full;
  logic                     do_insert;
  logic                     do_pop;
  ccf_status_t              status;
  ccf_entry_t               pop_entry;

  ccf_entry_t               cell_q  [QUEUE_DEPTH];
  ccf_entry_t               cell_up [QUEUE_DEPTH];
  ccf_cell_ctrl_t           cell_ctrl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   hits;

  // Control FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    exec_go   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          exec_go   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_code_r <= WRITE_CODE_RST;
    end else if (cfg_wr_en) begin
      write_code_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r        <= in_tuser;
      item_r.file  <= in_tdata[FILE_W-1:0];
      item_r.cmd   <= in_tdata[FILE_W +: CMD_W];
      item_r.block <= in_tdata[FILE_W+CMD_W +: BLOCK_W];
    end
  end

  // Row of cells; cell 0 is the head, a pop moves every entry down by one.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign cell_up[i] = cell_q[i];
    end else begin : g_mid
      assign cell_up[i] = cell_q[i+1];
    end

    assign cell_ctrl[i].shift = do_pop;
    assign cell_ctrl[i].load  = do_insert && (count_r == CNT_W'(i));
    assign cell_ctrl[i].live  = (CNT_W'(i) < count_r);

    ccf_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .entry_up   (cell_up[i]),
      .entry_new  (item_r),
      .write_code (write_code_r),
      .cmp_addr   (item_r.block),
      .entry_q    (cell_q[i]),
      .hit_q      (hits[i])
    );
  end

  assign any_hit   = |hits;
  assign is_write  = (item_r.cmd == write_code_r);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_insert = exec_go && (req_r == REQ_INSERT) && !(is_write && any_hit) && !full;
  assign do_pop    = exec_go && (req_r == REQ_REMOVE) && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    peak_nxt  = peak_r;
    pop_entry = '0;
    status    = STAT_EMPTY;
    if (req_r == REQ_INSERT) begin
      if (is_write && any_hit) begin
        status = STAT_COALESCED;
      end else if (full) begin
        status = STAT_FULL;
      end else begin
        status    = STAT_INSERTED;
        count_nxt = count_r + 1'b1;
        if (count_nxt > peak_r) begin
          peak_nxt = count_nxt;
        end
      end
    end else if (count_r != '0) begin
      status    = STAT_POPPED;
      count_nxt = count_r - 1'b1;
      pop_entry = cell_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      peak_r  <= '0;
    end else if (exec_go) begin
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_user_r <= status;
      out_data_r <= {2'b00,
                     OCC_W'(peak_nxt),
                     OCC_W'(count_nxt),
                     pop_entry.block,
                     pop_entry.cmd,
                     pop_entry.file};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r)
    else $error("peak mark below fill count");

  a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(exec_go))
    else $error("fill count changed outside execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without an execute cycle");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_insert && do_pop))
    else $error("insert and pop in the same cycle");
`endif

endmodule
